// ----- hdl/i2csrb_pkg.sv -----
package i2csrb_pkg;

	localparam int unsigned REG_COUNT_DEF = 32;

	localparam int unsigned FUNC_W  = 4;
	localparam int unsigned BYTE_W  = 8;
	localparam int unsigned HADDR_W = 5;

	// event codes carried in the func field
	typedef enum logic [FUNC_W-1:0] {
		FUNC_ADDR_WR = 4'd0,
		FUNC_RX_ACK  = 4'd1,
		FUNC_RX_NACK = 4'd2,
		FUNC_STOP    = 4'd3,
		FUNC_ADDR_RD = 4'd4,
		FUNC_TX_ACK  = 4'd5,
		FUNC_TX_NACK = 4'd6,
		FUNC_BUS_ERR = 4'd7,
		FUNC_OTHER   = 4'd8,
		FUNC_HOST_WR = 4'd9,
		FUNC_HOST_RD = 4'd10
	} func_t;

	typedef struct packed {
		logic [FUNC_W-1:0]  func;
		logic [BYTE_W-1:0]  bus_byte;
		logic [HADDR_W-1:0] host_addr;
		logic [BYTE_W-1:0]  host_data;
	} evt_t;

	typedef struct packed {
		logic [BYTE_W-1:0] tx_byte;
		logic              tx_load;
		logic              send_stop;
		logic [BYTE_W-1:0] read_data;
	} res_t;

endpackage

// ----- hdl/i2csrb_evt_if.sv -----
interface i2csrb_evt_if;
	logic               valid;
	logic               ready;
	i2csrb_pkg::evt_t   payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

// ----- hdl/i2csrb_res_if.sv -----
interface i2csrb_res_if;
	logic               valid;
	logic               ready;
	i2csrb_pkg::res_t   payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

// ----- hdl/i2c_slave_register_bank_core.sv -----
// Two-wire slave register bank.
// evt: one bus or host event per transaction (func, bus_byte, host_addr,
//   host_data). res: exactly one result per event (tx_byte, tx_load,
//   send_stop, read_data), in event order.
// The bank lives in a RAM with one write and one registered read port.
// An event's bank access is issued at the edge that accepts it; the read
// stage then holds the event while the RAM data arrives, and the result
// register takes it next. One event per cycle is sustained while res does
// not stall; the bank read port and the result register set that figure.
// Reset clears the pointer, both byte counters and the per-entry valid
// bits, so every register reads as zero until written. No clearing pass
// is needed; events are taken right after reset.
// When res stalls, the result register holds, an event in the read stage
// waits behind it, and a full read stage drops evt.ready until res drains.
module i2c_slave_register_bank_core #(
	parameter int unsigned REG_COUNT = i2csrb_pkg::REG_COUNT_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	i2csrb_evt_if.sink          evt,
	i2csrb_res_if.source        res
);

	localparam int unsigned IDX_W = $clog2(REG_COUNT);
	localparam int unsigned CNT_W = $clog2(REG_COUNT + 2);
	localparam int unsigned BW    = i2csrb_pkg::BYTE_W;
	localparam int unsigned TBL_N = 2 ** BW;

	localparam logic [CNT_W-1:0] CNT_FULL   = CNT_W'(REG_COUNT);
	localparam logic [CNT_W-1:0] CNT_CLOSED = CNT_W'(REG_COUNT + 1);
	localparam logic [IDX_W:0]   SUM_WRAP   = (IDX_W + 1)'(REG_COUNT);

	// byte value modulo REG_COUNT, constant table
	logic [IDX_W-1:0] mod_tbl [TBL_N];
	for (genvar g = 0; g < TBL_N; g++) begin : g_mod
		assign mod_tbl[g] = IDX_W'(g % REG_COUNT);
	end

	logic [IDX_W-1:0] ptr_q;
	logic [CNT_W-1:0] rx_cnt_q;
	logic [CNT_W-1:0] tx_cnt_q;
	logic [REG_COUNT-1:0] vld_q;

	logic             acc;
	logic             s1_adv;
	logic [BW-1:0]    func_b;
	logic [IDX_W-1:0] host_idx;
	logic [IDX_W-1:0] off;
	logic [IDX_W:0]   sum;
	logic [IDX_W-1:0] bank_idx;
	logic             rx_wr;
	logic             tx_rd;
	logic             host_wr;
	logic             host_rd;
	logic             we;
	logic             re;
	logic [IDX_W-1:0] waddr;
	logic [IDX_W-1:0] raddr;
	logic [BW-1:0]    wdata;
	logic [BW-1:0]    rdata;

	logic             valid_s1;
	logic             tx_rd_s1;
	logic             tx_load_s1;
	logic             stop_s1;
	logic             host_rd_s1;
	logic             rvld_s1;

	logic             res_valid_q;
	i2csrb_pkg::res_t res_q;

	assign s1_adv    = !res_valid_q || res.ready;
	assign evt.ready = !valid_s1 || s1_adv;
	assign acc       = evt.valid && evt.ready;

	assign func_b   = BW'(evt.payload.host_addr);
	assign host_idx = mod_tbl[func_b];

	always_comb begin
		host_wr = evt.payload.func == i2csrb_pkg::FUNC_HOST_WR;
		host_rd = evt.payload.func == i2csrb_pkg::FUNC_HOST_RD;
		rx_wr   = evt.payload.func == i2csrb_pkg::FUNC_RX_ACK
			&& rx_cnt_q != '0 && rx_cnt_q <= CNT_FULL;
		tx_rd   = evt.payload.func == i2csrb_pkg::FUNC_ADDR_RD
			|| (evt.payload.func == i2csrb_pkg::FUNC_TX_ACK && tx_cnt_q < CNT_FULL);

		// rx writes at ptr + count - 1, tx reads at ptr + count, address read at ptr
		if (evt.payload.func == i2csrb_pkg::FUNC_RX_ACK) begin
			off = rx_cnt_q[IDX_W-1:0] - IDX_W'(1);
		end else if (evt.payload.func == i2csrb_pkg::FUNC_ADDR_RD) begin
			off = '0;
		end else begin
			off = tx_cnt_q[IDX_W-1:0];
		end
		sum      = {1'b0, ptr_q} + {1'b0, off};
		bank_idx = (sum >= SUM_WRAP) ? IDX_W'(sum - SUM_WRAP) : sum[IDX_W-1:0];

		we    = acc && (rx_wr || host_wr);
		re    = acc && (tx_rd || host_rd);
		waddr = host_wr ? host_idx : bank_idx;
		raddr = host_rd ? host_idx : bank_idx;
		wdata = host_wr ? evt.payload.host_data : evt.payload.bus_byte;
	end

	i2csrb_ram #(
		.WIDTH (BW),
		.DEPTH (REG_COUNT)
	) u_bank (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.re    (re),
		.raddr (raddr),
		.rdata (rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ptr_q    <= '0;
			rx_cnt_q <= '0;
			tx_cnt_q <= '0;
			vld_q    <= '0;
		end else if (acc) begin
			if (we) begin
				vld_q[waddr] <= 1'b1;
			end
			case (evt.payload.func)
				i2csrb_pkg::FUNC_ADDR_WR: begin
					rx_cnt_q <= '0;
				end
				i2csrb_pkg::FUNC_RX_ACK: begin
					if (rx_cnt_q == '0) begin
						ptr_q <= mod_tbl[evt.payload.bus_byte];
					end
					if (rx_cnt_q <= CNT_FULL) begin
						rx_cnt_q <= rx_cnt_q + CNT_W'(1);
					end
				end
				i2csrb_pkg::FUNC_RX_NACK, i2csrb_pkg::FUNC_STOP: begin
					rx_cnt_q <= CNT_CLOSED;
				end
				i2csrb_pkg::FUNC_ADDR_RD: begin
					tx_cnt_q <= CNT_W'(1);
				end
				i2csrb_pkg::FUNC_TX_ACK: begin
					if (tx_cnt_q < CNT_FULL) begin
						tx_cnt_q <= tx_cnt_q + CNT_W'(1);
					end
				end
				i2csrb_pkg::FUNC_TX_NACK: begin
					tx_cnt_q <= CNT_FULL;
				end
				i2csrb_pkg::FUNC_BUS_ERR: begin
					rx_cnt_q <= CNT_CLOSED;
					tx_cnt_q <= CNT_FULL;
				end
				default: begin
				end
			endcase
		end
	end

	// read stage: waits for the registered RAM data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (acc) begin
			valid_s1 <= 1'b1;
		end else if (s1_adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			tx_rd_s1   <= tx_rd;
			tx_load_s1 <= evt.payload.func == i2csrb_pkg::FUNC_ADDR_RD
				|| evt.payload.func == i2csrb_pkg::FUNC_TX_ACK;
			stop_s1    <= evt.payload.func == i2csrb_pkg::FUNC_BUS_ERR;
			host_rd_s1 <= host_rd;
			rvld_s1    <= vld_q[raddr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (valid_s1 && s1_adv) begin
			res_valid_q <= 1'b1;
		end else if (res.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1 && s1_adv) begin
			res_q.tx_byte   <= (tx_rd_s1 && rvld_s1) ? rdata : '0;
			res_q.tx_load   <= tx_load_s1;
			res_q.send_stop <= stop_s1;
			res_q.read_data <= (host_rd_s1 && rvld_s1) ? rdata : '0;
		end
	end

	assign res.valid   = res_valid_q;
	assign res.payload = res_q;

endmodule

// ----- hdl/i2csrb_ram.sv -----
module i2csrb_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ----- hdl/i2csrb_chk.sv -----
module i2csrb_chk (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          res_valid,
	input logic                          res_ready,
	input logic [i2csrb_pkg::BYTE_W-1:0] tx_byte,
	input logic                          tx_load,
	input logic                          send_stop,
	input logic [i2csrb_pkg::BYTE_W-1:0] read_data
);

	// a stalled transaction keeps its payload
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(tx_byte) && $stable(tx_load)
			&& $stable(send_stop) && $stable(read_data))
		else $error("result changed while stalled");

	a_tx_excl: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> !(tx_load && send_stop))
		else $error("transmit load and stop request together");

	a_tx_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !tx_load |-> tx_byte == '0)
		else $error("transmit byte without load");

	a_host_only: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && read_data != '0 |-> !tx_load && !send_stop)
		else $error("host read data on a bus event");

endmodule

bind i2c_slave_register_bank_core i2csrb_chk u_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.res_valid (res.valid),
	.res_ready (res.ready),
	.tx_byte   (res.payload.tx_byte),
	.tx_load   (res.payload.tx_load),
	.send_stop (res.payload.send_stop),
	.read_data (res.payload.read_data)
);
